FILE: design/cpow_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package cpow_pkg;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;        // capture a new input item
    logic set_dz;      // zero base with negative exponent
    logic prod;        // register the four partial products
    logic prod_sq;     // operands are x*x instead of q*x
    logic fin_q;       // running product takes the combined result
    logic fin_x;       // base takes the combined result (squaring)
    logic den_load;    // load |x|^2 and start the reciprocal divide
    logic div_step;    // one restoring divide step on both parts
    logic recip_load;  // base takes the saturated reciprocal
    logic q_copy;      // running product is exactly one: copy the base
    logic shift_u;     // drop the exponent bit just used
    logic out_load;    // move the result into the output register
  } cpow_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic exp_zero;
    logic exp_neg;
    logic base_zero;
    logic u_lsb;
    logic u_last;
    logic q_one;
    logic out_busy;
  } cpow_sts_t;

endpackage

`default_nettype wire

FILE: design/cpow_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module cpow_ctrl import cpow_pkg::*; #(
  parameter int DIV_STEPS = 64
) (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      in_valid,
  output logic           in_stall,
  input  wire cpow_sts_t sts,
  output cpow_cmd_t      cmd
);

  localparam int CW = $clog2(DIV_STEPS);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_CHECK = 4'd1;
  localparam logic [3:0] S_DEN_A = 4'd2;
  localparam logic [3:0] S_DIV   = 4'd3;
  localparam logic [3:0] S_RECIP = 4'd4;
  localparam logic [3:0] S_BIT   = 4'd5;
  localparam logic [3:0] S_MUL_F = 4'd6;
  localparam logic [3:0] S_NEXT  = 4'd7;
  localparam logic [3:0] S_SQR_F = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;

  logic [3:0]    state_r, state_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  // A new item is taken only while the sequencer is idle.
  assign in_stall = (state_r != S_IDLE);

  // Sequencer: reciprocal first if needed, then square-and-multiply from the LSB.
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    cmd       = '0;
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_CHECK;
        end
      end
      S_CHECK: begin
        if (sts.exp_zero) begin
          state_nxt = S_FIN;
        end else if (sts.exp_neg && sts.base_zero) begin
          cmd.set_dz = 1'b1;
          state_nxt  = S_FIN;
        end else if (sts.exp_neg) begin
          cmd.prod    = 1'b1;
          cmd.prod_sq = 1'b1;
          state_nxt   = S_DEN_A;
        end else begin
          state_nxt = S_BIT;
        end
      end
      S_DEN_A: begin
        cmd.den_load = 1'b1;
        cnt_nxt      = '0;
        state_nxt    = S_DIV;
      end
      S_DIV: begin
        cmd.div_step = 1'b1;
        cnt_nxt      = cnt_r + 1'b1;
        if (cnt_r == CW'(DIV_STEPS - 1)) begin
          state_nxt = S_RECIP;
        end
      end
      S_RECIP: begin
        cmd.recip_load = 1'b1;
        state_nxt      = S_BIT;
      end
      S_BIT: begin
        if (sts.u_lsb) begin
          if (sts.q_one) begin
            cmd.q_copy = 1'b1;
            state_nxt  = S_NEXT;
          end else begin
            cmd.prod  = 1'b1;
            state_nxt = S_MUL_F;
          end
        end else begin
          state_nxt = S_NEXT;
        end
      end
      S_MUL_F: begin
        cmd.fin_q = 1'b1;
        state_nxt = S_NEXT;
      end
      S_NEXT: begin
        cmd.shift_u = 1'b1;
        if (sts.u_last) begin
          state_nxt = S_FIN;
        end else begin
          cmd.prod    = 1'b1;
          cmd.prod_sq = 1'b1;
          state_nxt   = S_SQR_F;
        end
      end
      S_SQR_F: begin
        cmd.fin_x = 1'b1;
        state_nxt = S_BIT;
      end
      S_FIN: begin
        if (!sts.out_busy) begin
          cmd.out_load = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // State and divide step counter.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

`default_nettype wire

FILE: design/cpow_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module cpow_dp import cpow_pkg::*; #(
  parameter int W = 32,
  parameter int F = 16,
  parameter int E = 16
) (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic signed [W-1:0] in_base_re,
  input  wire logic signed [W-1:0] in_base_im,
  input  wire logic signed [E-1:0] in_exponent,
  input  wire cpow_cmd_t           cmd,
  output cpow_sts_t                sts,
  output logic                     out_valid,
  input  wire logic                out_stall,
  output logic signed [W-1:0]      out_result_re,
  output logic signed [W-1:0]      out_result_im,
  output logic                     out_overflow,
  output logic                     out_div_by_zero
);

  localparam int PW = 2 * W;
  localparam int SW = 2 * W + 1;
  localparam int DW = 2 * W;
  localparam int NW = W + 2 * F;

  localparam logic [W-1:0]  MAX_V   = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0]  MIN_V   = {1'b1, {(W-1){1'b0}}};
  localparam bit            ONE_OVF = (F > W - 2);
  localparam logic [W-1:0]  ONE_V   = ONE_OVF ? MAX_V : (W'(1) << F);
  localparam logic [NW-1:0] HALF    = NW'(1) << (W - 1);

  // Saturate a shifted product to the word range; the top bit is the overflow flag.
  function automatic logic [W:0] sat_word(input logic signed [SW-1:0] v);
    logic [SW-W:0] hi;
    logic [W:0]    res;
    hi = v[SW-1:W-1];
    if (hi == {(SW-W+1){v[SW-1]}}) begin
      res = {1'b0, v[W-1:0]};
    end else begin
      res = {1'b1, (v[SW-1] ? MIN_V : MAX_V)};
    end
    return res;
  endfunction

  // Apply the sign to a quotient magnitude and saturate.
  function automatic logic [W:0] sat_quot(input logic [NW-1:0] q, input logic neg);
    logic [NW-1:0] nq;
    logic [W:0]    res;
    nq = ~q + 1'b1;
    if (!neg) begin
      res = (q >= HALF) ? {1'b1, MAX_V} : {1'b0, q[W-1:0]};
    end else if (q > HALF) begin
      res = {1'b1, MIN_V};
    end else begin
      res = {1'b0, nq[W-1:0]};
    end
    return res;
  endfunction

  logic signed [W-1:0]  xr_r, xi_r, qr_r, qi_r;
  logic                 q_one_r, eneg_r, ovf_r, dz_r;
  logic [E-1:0]         u_r;
  logic signed [PW-1:0] p0_r, p1_r, p2_r, p3_r;
  logic [DW-1:0]        den_r, rem_re_r, rem_im_r;
  logic [NW-1:0]        num_re_r, num_im_r;
  logic                 neg_re_r, neg_im_r;
  logic                 out_valid_r;
  logic signed [W-1:0]  out_re_r, out_im_r;
  logic                 out_ovf_r, out_dz_r;

  // Operand selection and the four real products of one complex multiply.
  logic signed [W-1:0]  opa_re, opa_im;
  logic signed [PW-1:0] p0_nxt, p1_nxt, p2_nxt, p3_nxt;

  assign opa_re = cmd.prod_sq ? xr_r : qr_r;
  assign opa_im = cmd.prod_sq ? xi_r : qi_r;
  assign p0_nxt = opa_re * xr_r;
  assign p1_nxt = opa_im * xi_r;
  assign p2_nxt = opa_re * xi_r;
  assign p3_nxt = opa_im * xr_r;

  // Combine, floor-shift by the fraction width and saturate.
  logic signed [SW-1:0] re_full, im_full, re_sh, im_sh;
  logic [W:0]           re_sat, im_sat;

  assign re_full = SW'(p0_r) - SW'(p1_r);
  assign im_full = SW'(p2_r) + SW'(p3_r);
  assign re_sh   = re_full >>> F;
  assign im_sh   = im_full >>> F;
  assign re_sat  = sat_word(re_sh);
  assign im_sat  = sat_word(im_sh);

  // Magnitude of the squared modulus and of the base parts for the reciprocal.
  logic [DW-1:0] den_nxt;
  logic [W-1:0]  mag_re, mag_im;
  logic [E-1:0]  u_in;

  assign den_nxt = p0_r + p1_r;
  assign mag_re  = xr_r[W-1] ? (~xr_r + 1'b1) : xr_r;
  assign mag_im  = xi_r[W-1] ? (~xi_r + 1'b1) : xi_r;
  assign u_in    = in_exponent[E-1] ? (~in_exponent + 1'b1) : in_exponent;

  // One restoring divide step for each part; both share the denominator.
  logic [DW:0]   t_re, t_im;
  logic          ge_re, ge_im;
  logic [DW-1:0] rem_re_nxt, rem_im_nxt;
  logic [DW:0]   d_re, d_im;

  assign t_re       = {rem_re_r, num_re_r[NW-1]};
  assign t_im       = {rem_im_r, num_im_r[NW-1]};
  assign ge_re      = (t_re >= {1'b0, den_r});
  assign ge_im      = (t_im >= {1'b0, den_r});
  assign d_re       = t_re - {1'b0, den_r};
  assign d_im       = t_im - {1'b0, den_r};
  assign rem_re_nxt = ge_re ? d_re[DW-1:0] : t_re[DW-1:0];
  assign rem_im_nxt = ge_im ? d_im[DW-1:0] : t_im[DW-1:0];

  logic [W:0] rq_re, rq_im;
  assign rq_re = sat_quot(num_re_r, neg_re_r);
  assign rq_im = sat_quot(num_im_r, neg_im_r);

  // Working registers of one item.
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      xr_r    <= in_base_re;
      xi_r    <= in_base_im;
      u_r     <= u_in;
      eneg_r  <= in_exponent[E-1];
      q_one_r <= 1'b1;
      ovf_r   <= 1'b0;
      dz_r    <= 1'b0;
    end
    if (cmd.set_dz) begin
      dz_r    <= 1'b1;
      q_one_r <= 1'b0;
      qr_r    <= '0;
      qi_r    <= '0;
    end
    if (cmd.prod) begin
      p0_r <= p0_nxt;
      p1_r <= p1_nxt;
      p2_r <= p2_nxt;
      p3_r <= p3_nxt;
    end
    if (cmd.fin_q) begin
      qr_r  <= re_sat[W-1:0];
      qi_r  <= im_sat[W-1:0];
      ovf_r <= ovf_r | re_sat[W] | im_sat[W];
    end
    if (cmd.fin_x) begin
      xr_r  <= re_sat[W-1:0];
      xi_r  <= im_sat[W-1:0];
      ovf_r <= ovf_r | re_sat[W] | im_sat[W];
    end
    if (cmd.q_copy) begin
      qr_r    <= xr_r;
      qi_r    <= xi_r;
      q_one_r <= 1'b0;
    end
    if (cmd.shift_u) begin
      u_r <= u_r >> 1;
    end
    if (cmd.den_load) begin
      den_r    <= den_nxt;
      rem_re_r <= '0;
      rem_im_r <= '0;
      num_re_r <= {mag_re, {(2*F){1'b0}}};
      num_im_r <= {mag_im, {(2*F){1'b0}}};
      neg_re_r <= xr_r[W-1];
      neg_im_r <= (xi_r != '0) && !xi_r[W-1];
    end
    if (cmd.div_step) begin
      rem_re_r <= rem_re_nxt;
      rem_im_r <= rem_im_nxt;
      num_re_r <= {num_re_r[NW-2:0], ge_re};
      num_im_r <= {num_im_r[NW-2:0], ge_im};
    end
    if (cmd.recip_load) begin
      xr_r  <= rq_re[W-1:0];
      xi_r  <= rq_im[W-1:0];
      ovf_r <= ovf_r | rq_re[W] | rq_im[W];
    end
  end

  // Output register: holds a finished item until the consumer takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.out_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_re_r  <= q_one_r ? ONE_V : qr_r;
      out_im_r  <= q_one_r ? '0 : qi_r;
      out_ovf_r <= ovf_r | (q_one_r & ONE_OVF);
      out_dz_r  <= dz_r;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_result_re   = out_re_r;
  assign out_result_im   = out_im_r;
  assign out_overflow    = out_ovf_r;
  assign out_div_by_zero = out_dz_r;

  // Status for the controller.
  assign sts.exp_zero  = (u_r == '0);
  assign sts.exp_neg   = eneg_r;
  assign sts.base_zero = (xr_r == '0) && (xi_r == '0);
  assign sts.u_lsb     = u_r[0];
  assign sts.u_last    = (u_r[E-1:1] == '0);
  assign sts.q_one     = q_one_r;
  assign sts.out_busy  = out_valid_r & out_stall;

endmodule

`default_nettype wire

FILE: design/complex_integer_power.sv
`timescale 1ns / 1ps
`default_nettype none

// Raises a complex signed fixed-point base (FRAC_BITS fraction bits) to a signed
// integer power, one item at a time. A sequencer drives one shared complex
// multiplier: it forms four registered real products, and in the cycle after
// that it combines, floor-shifts and saturates them. The exponent magnitude is
// scanned from its low bit: a set bit multiplies the running product by the base
// (the first one copies the base), and the base is squared before each further bit.
// A negative exponent first forms the reciprocal conj(a)/|a|^2 with a restoring
// divider that retires one quotient bit per cycle. Exponent zero gives 1+0i, and
// a zero base with a negative exponent gives zero with div_by_zero set. Any
// saturation along the way sets overflow. The input stalls while an item is in
// progress; a finished item waits in the output register.
module complex_integer_power import cpow_pkg::*; #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16,
  parameter int EXP_BITS  = 16
) (
  input  wire logic                        clk,
  input  wire logic                        rst_n,
  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [WORD_BITS-1:0] in_base_re,
  input  wire logic signed [WORD_BITS-1:0] in_base_im,
  input  wire logic signed [EXP_BITS-1:0]  in_exponent,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic signed [WORD_BITS-1:0]      out_result_re,
  output logic signed [WORD_BITS-1:0]      out_result_im,
  output logic                             out_overflow,
  output logic                             out_div_by_zero
);

  cpow_cmd_t cmd;
  cpow_sts_t sts;

  // Sequencer.
  cpow_ctrl #(
    .DIV_STEPS(WORD_BITS + 2 * FRAC_BITS)
  ) u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .sts     (sts),
    .cmd     (cmd)
  );

  // Multiplier, divider, working registers and output register.
  cpow_dp #(
    .W(WORD_BITS),
    .F(FRAC_BITS),
    .E(EXP_BITS)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_base_re     (in_base_re),
    .in_base_im     (in_base_im),
    .in_exponent    (in_exponent),
    .cmd            (cmd),
    .sts            (sts),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_re  (out_result_re),
    .out_result_im  (out_result_im),
    .out_overflow   (out_overflow),
    .out_div_by_zero(out_div_by_zero)
  );

endmodule

`default_nettype wire

FILE: dv/testbench.sv
`timescale 1ns / 1ps

module testbench;

  localparam int WORD_BITS = 32;
  localparam int FRAC_BITS = 16;
  localparam int EXP_BITS = 16;
  localparam int STALL_LIMIT = 4000;
  localparam int LONG_HOLD = 300;
  localparam int REPORT_LIMIT = 100;

  typedef logic signed [127:0] wide_t;
  typedef logic signed [WORD_BITS-1:0] word_t;
  typedef logic signed [EXP_BITS-1:0] expo_t;

  localparam wide_t SAT_HI = (wide_t'(1) <<< (WORD_BITS - 1)) - 1;
  localparam wide_t SAT_LO = -(wide_t'(1) <<< (WORD_BITS - 1));

  localparam word_t ONE = word_t'(1) <<< FRAC_BITS;
  localparam word_t W_MAX = SAT_HI[WORD_BITS-1:0];
  localparam word_t W_MIN = SAT_LO[WORD_BITS-1:0];

  typedef struct packed {
    word_t re;
    word_t im;
    logic  ovf;
    logic  dz;
  } power_t;

  typedef enum int {PART_UNIT, PART_FULL, PART_TINY, PART_SCALED, PART_EDGE} part_kind_e;

  // Predicts each power and keeps the results still owed by the block, oldest first.
  class power_scoreboard;
    power_t pending_powers[$];
    int     mismatch_count;

    function wide_t clamp_word(wide_t v, inout logic ovf);
      if (v > SAT_HI) begin
        ovf = 1'b1;
        return SAT_HI;
      end
      if (v < SAT_LO) begin
        ovf = 1'b1;
        return SAT_LO;
      end
      return v;
    endfunction

    // Exact complex product, floor-shifted back to the fixed-point scale.
    function void complex_mul(output wide_t pr, output wide_t pi, input wide_t ar,
                              input wide_t ai, input wide_t br, input wide_t bi,
                              inout logic ovf);
      wide_t re_full;
      wide_t im_full;
      re_full = ar * br - ai * bi;
      im_full = ar * bi + ai * br;
      pr = clamp_word(re_full >>> FRAC_BITS, ovf);
      pi = clamp_word(im_full >>> FRAC_BITS, ovf);
    endfunction

    // One part of the reciprocal, quotient truncated toward zero.
    function wide_t recip_part(wide_t num, wide_t den, inout logic ovf);
      wide_t quo;
      quo = ((num < 0) ? -num : num) / den;
      if (num < 0) quo = -quo;
      return clamp_word(quo, ovf);
    endfunction

    function power_t raise_power(word_t base_re, word_t base_im, expo_t exponent);
      wide_t  qr;
      wide_t  qi;
      wide_t  xr;
      wide_t  xi;
      wide_t  den;
      wide_t  scale;
      int     mag;
      logic   ovf;
      logic   dz;
      power_t res;
      qr = wide_t'(1) <<< FRAC_BITS;
      qi = '0;
      xr = base_re;
      xi = base_im;
      ovf = 1'b0;
      dz = 1'b0;
      mag = (exponent < 0) ? -int'(exponent) : int'(exponent);
      if (mag == 0) begin
        qr = clamp_word(qr, ovf);
      end else if (exponent < 0 && base_re == 0 && base_im == 0) begin
        qr = '0;
        dz = 1'b1;
      end else begin
        if (exponent < 0) begin
          den = xr * xr + xi * xi;
          scale = wide_t'(1) <<< (2 * FRAC_BITS);
          xr = recip_part(wide_t'(base_re) * scale, den, ovf);
          xi = recip_part(-(wide_t'(base_im) * scale), den, ovf);
        end
        // Square-and-multiply from the low exponent bit; no square after the top bit.
        while (mag != 0) begin
          if (mag[0]) complex_mul(qr, qi, qr, qi, xr, xi, ovf);
          mag = mag >> 1;
          if (mag != 0) complex_mul(xr, xi, xr, xi, xr, xi, ovf);
        end
      end
      res.re = qr[WORD_BITS-1:0];
      res.im = qi[WORD_BITS-1:0];
      res.ovf = ovf;
      res.dz = dz;
      return res;
    endfunction

    function void note_item(word_t base_re, word_t base_im, expo_t exponent);
      pending_powers.push_back(raise_power(base_re, base_im, exponent));
    endfunction

    function void flag(string field, logic signed [63:0] want, logic signed [63:0] got);
      mismatch_count++;
      if (mismatch_count <= REPORT_LIMIT)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, got);
    endfunction

    function void check_item(power_t got);
      power_t want;
      if (pending_powers.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= REPORT_LIMIT)
          $display("%0t: unexpected result, expected none, actual re %0d im %0d",
                   $time, got.re, got.im);
        return;
      end
      want = pending_powers.pop_front();
      if (got.re !== want.re) flag("result_re", want.re, got.re);
      if (got.im !== want.im) flag("result_im", want.im, got.im);
      if (got.ovf !== want.ovf) flag("overflow", want.ovf, got.ovf);
      if (got.dz !== want.dz) flag("div_by_zero", want.dz, got.dz);
    endfunction
  endclass

  logic  clk;
  logic  rst_n;
  logic  in_valid;
  logic  in_stall;
  word_t in_base_re;
  word_t in_base_im;
  expo_t in_exponent;
  logic  out_valid;
  logic  out_stall;
  word_t out_result_re;
  word_t out_result_im;
  logic  out_overflow;
  logic  out_div_by_zero;

  power_scoreboard sb;
  int tx_idle_pct;
  int rx_idle_pct;
  bit rx_hold_req;
  int quiet_cycles;

  complex_integer_power #(
    .WORD_BITS(WORD_BITS),
    .FRAC_BITS(FRAC_BITS),
    .EXP_BITS (EXP_BITS)
  ) uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_base_re     (in_base_re),
    .in_base_im     (in_base_im),
    .in_exponent    (in_exponent),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_result_re  (out_result_re),
    .out_result_im  (out_result_im),
    .out_overflow   (out_overflow),
    .out_div_by_zero(out_div_by_zero)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Watch both channels at the rising edge; end the run if nothing moves for too long.
  always @(posedge clk) begin
    if (rst_n) begin
      quiet_cycles++;
      if (in_valid && !in_stall) begin
        sb.note_item(in_base_re, in_base_im, in_exponent);
        quiet_cycles = 0;
      end
      if (out_valid && !out_stall) begin
        sb.check_item('{out_result_re, out_result_im, out_overflow, out_div_by_zero});
        quiet_cycles = 0;
      end
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("status: fail");
        $finish;
      end
    end
  end

  // Result side: random stall bursts, plus one long hold-off on request.
  initial begin
    out_stall = 1'b0;
    forever begin
      @(negedge clk);
      if (rx_hold_req) begin
        out_stall <= 1'b1;
        repeat (LONG_HOLD) @(negedge clk);
        out_stall <= 1'b0;
        rx_hold_req = 1'b0;
      end else if ($urandom_range(99) < rx_idle_pct) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 12)) @(negedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  // Offer one item and hold it until accepted; returns at the following falling edge.
  task automatic send_item(input word_t re, input word_t im, input expo_t e);
    if ($urandom_range(99) < tx_idle_pct) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_base_re <= re;
    in_base_im <= im;
    in_exponent <= e;
    do @(posedge clk); while (in_stall !== 1'b0);
    @(negedge clk);
  endtask

  // Stop offering and wait until every predicted result has come out.
  task automatic wait_for_results();
    in_valid <= 1'b0;
    @(negedge clk);
    while (sb.pending_powers.size() != 0) @(negedge clk);
  endtask

  function automatic word_t pick_part(part_kind_e kind);
    word_t edges[7];
    edges = '{0, 1, -1, ONE, -ONE, W_MAX, W_MIN};
    case (kind)
      PART_UNIT:   return word_t'(int'($urandom_range(2 * 131072)) - 131072);
      PART_FULL:   return word_t'($urandom);
      PART_TINY:   return word_t'(int'($urandom_range(510)) - 255);
      PART_SCALED: return word_t'($signed($urandom) >>> $urandom_range(0, 31));
      default:     return edges[$urandom_range(6)];
    endcase
  endfunction

  // Bases near the unit circle are the largest share, short exponents the majority,
  // so that powers stay in range; the rest spans full fields, real and zero bases.
  task automatic send_random();
    part_kind_e kind;
    word_t      re;
    word_t      im;
    expo_t      e;
    int         pick;
    pick = $urandom_range(99);
    if (pick < 45) kind = PART_UNIT;
    else if (pick < 60) kind = PART_FULL;
    else if (pick < 72) kind = PART_TINY;
    else if (pick < 87) kind = PART_SCALED;
    else kind = PART_EDGE;
    re = pick_part(kind);
    im = ($urandom_range(99) < 20) ? '0 : pick_part(kind);
    if ($urandom_range(99) < 5) begin
      re = '0;
      im = '0;
    end
    pick = $urandom_range(99);
    if (pick < 65) e = expo_t'(int'($urandom_range(24)) - 12);
    else if (pick < 80) e = expo_t'(int'($urandom_range(80)) - 40);
    else e = expo_t'($urandom);
    send_item(re, im, e);
  endtask

  initial begin
    int idle_levels[4];
    idle_levels = '{0, 5, 20, 50};
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_base_re = '0;
    in_base_im = '0;
    in_exponent = '0;
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    rx_hold_req = 1'b0;
    quiet_cycles = 0;
    sb = new;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed cases: zero exponent, zero base, field extremes, saturation,
    // reciprocal overflow and floor truncation of negative products.
    tx_idle_pct = 15;
    rx_idle_pct = 15;
    send_item(0, 0, 0);
    send_item(W_MAX, W_MIN, 0);
    send_item(0, 0, -1);
    send_item(0, 0, expo_t'(16'sh8000));
    send_item(0, 0, 5);
    send_item(ONE, 0, 16'sh7fff);
    send_item(-ONE, 0, expo_t'(16'sh8000));
    send_item(0, ONE, 3);
    send_item(ONE / 2, 0, 2);
    send_item(2 * ONE, 0, 20);
    send_item(1, 0, -1);
    send_item(W_MIN, W_MIN, -1);
    send_item(W_MIN, 0, 2);
    send_item(W_MAX, W_MAX, 1);
    send_item(W_MAX, W_MAX, -1);
    send_item(3 * ONE, -4 * ONE, -2);
    send_item(ONE + ONE / 4, ONE / 3, 7);
    send_item(-ONE / 2 + 1, 5, 3);
    send_item(ONE, ONE, 16);
    send_item(W_MIN, 0, 16'sh7fff);
    send_item(12345, -67890, -32767);
    send_item(0, -ONE, -1);
    wait_for_results();

    // Long hold-off on the result side while items keep coming.
    tx_idle_pct = 0;
    rx_hold_req = 1'b1;
    repeat (12) send_random();
    wait_for_results();

    // Random items in blocks with different amounts of idling on each side.
    for (int blk = 0; blk < 14; blk++) begin
      tx_idle_pct = idle_levels[$urandom_range(3)];
      rx_idle_pct = idle_levels[$urandom_range(3)];
      repeat (100) send_random();
      if (blk == 7) wait_for_results();
    end

    // Closing stretch at full rate on both sides.
    tx_idle_pct = 0;
    rx_idle_pct = 0;
    repeat (200) send_random();
    wait_for_results();
    repeat (200) @(posedge clk);
    if (sb.mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
